// ===== hw/rtl/gfps_pkg.sv =====
package gfps_pkg;

    // default sizes handed to the top level
    localparam int MAX_COLS_DEF     = 512;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // result queue between front and back, power of two
    localparam int QUEUE_DEPTH = 8;

    // fixed field widths
    localparam int ROW_W      = 16;
    localparam int COLS_REG_W = 10;
    localparam int LAYER_W    = 8;
    localparam int OUT_COL_W  = 9;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROWS  = 2'd0,
        REG_COLS  = 2'd1,
        REG_LAYER = 2'd2
    } t_cfg_reg;

    localparam logic [ROW_W-1:0]      ROWS_RESET  = 16'd181;
    localparam logic [COLS_REG_W-1:0] COLS_RESET  = 10'd361;
    localparam logic [LAYER_W-1:0]    LAYER_RESET = 8'd0;

    // item kind on the input tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // control and position of one item on its way to the output
    typedef struct packed {
        logic                 emit;
        logic                 interior;
        logic                 last;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [LAYER_W-1:0]   layer;
    } t_item_ctrl;

endpackage

// ===== hw/rtl/gfps_front.sv =====
module gfps_front #(
    parameter int MAX_COLS     = 512,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_func,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    input  logic [gfps_pkg::ROW_W-1:0]          i_rows,
    input  logic [gfps_pkg::COLS_REG_W-1:0]     i_cols,
    input  logic [gfps_pkg::LAYER_W-1:0]        i_layer,
    output gfps_pkg::t_item_ctrl                o_ctrl,
    output logic signed [SAMPLE_WIDTH-1:0]      o_centre,
    output logic signed [SAMPLE_WIDTH-1:0]      o_north,
    output logic signed [SAMPLE_WIDTH-1:0]      o_south,
    output logic signed [SAMPLE_WIDTH-1:0]      o_east,
    output logic signed [SAMPLE_WIDTH-1:0]      o_west
);
    import gfps_pkg::*;

    localparam int AW = $clog2(MAX_COLS);
    localparam int CW = (AW + 1 > COLS_REG_W) ? AW + 1 : COLS_REG_W;

    // position counters
    logic [AW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // line buffers
    logic signed [SAMPLE_WIDTH-1:0] r_line_above     [MAX_COLS];
    logic signed [SAMPLE_WIDTH-1:0] r_line_two_above [MAX_COLS];

    // stage after the buffer read
    t_item_ctrl                     r_s1_ctrl, n_s1_ctrl;
    logic                           r_s1_upd;
    logic [AW-1:0]                  r_s1_addr;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_south;
    logic signed [SAMPLE_WIDTH-1:0] r_centre, r_east, r_north;
    logic signed [SAMPLE_WIDTH-1:0] r_west;

    logic [ROW_W-1:0] rows_eff;
    logic [CW-1:0]    cols_wide, cols_eff, col_next_w;
    logic [AW-1:0]    east_addr;
    logic             frame_done, wrap, is_flush, is_sample, upd, fl, interior;

    // effective frame size and item classification
    always_comb begin
        rows_eff   = (i_rows == '0) ? ROW_W'(1) : i_rows;
        cols_wide  = CW'(i_cols);
        if (cols_wide == '0) begin
            cols_eff = CW'(1);
        end else if (cols_wide > CW'(MAX_COLS)) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = cols_wide;
        end
        frame_done = (r_row >= rows_eff);
        col_next_w = CW'(r_col) + CW'(1);
        wrap       = (col_next_w >= cols_eff);
        is_flush   = (i_func == FUNC_FLUSH);
        is_sample  = (i_func == FUNC_SAMPLE);
        upd        = i_accept && is_sample && !frame_done;
        fl         = i_accept && is_flush && frame_done;
        interior   = (r_row >= ROW_W'(2)) && (r_col != '0)
                     && ((CW'(r_col) + CW'(2)) <= cols_eff);
        east_addr  = r_col + AW'(1);
    end

    // next row and column
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (upd) begin
            if (wrap) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end else if (fl) begin
            if (wrap) begin
                n_col = '0;
                n_row = '0;
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    // control of the item as it leaves the buffer read
    always_comb begin
        n_s1_ctrl.emit     = (upd && (r_row != '0)) || fl;
        n_s1_ctrl.interior = upd && interior;
        n_s1_ctrl.last     = fl && wrap;
        n_s1_ctrl.row      = fl ? (rows_eff - ROW_W'(1)) : (r_row - ROW_W'(1));
        n_s1_ctrl.col      = OUT_COL_W'(r_col);
        n_s1_ctrl.layer    = i_layer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_ctrl <= '0;
            r_s1_upd  <= 1'b0;
            r_west    <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_s1_ctrl <= n_s1_ctrl;
            r_s1_upd  <= upd;
            if (r_s1_upd) begin
                r_west <= r_centre;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= r_col;
        r_s1_south <= i_sample;
    end

    // line buffers: read first, newest row written at accept,
    // older row written in the cycle after, from the centre read
    always_ff @(posedge i_clk) begin
        r_centre <= r_line_above[r_col];
        r_east   <= r_line_above[east_addr];
        r_north  <= r_line_two_above[r_col];
        if (upd) begin
            r_line_above[r_col] <= i_sample;
        end
        if (r_s1_upd) begin
            r_line_two_above[r_s1_addr] <= r_centre;
        end
    end

    assign o_ctrl   = r_s1_ctrl;
    assign o_centre = r_centre;
    assign o_north  = r_north;
    assign o_south  = r_s1_south;
    assign o_east   = r_east;
    assign o_west   = r_west;

`ifndef SYNTHESIS
    a_flush_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fl && wrap) |=> (r_row == '0 && r_col == '0))
        else $error("position not cleared after last flush item");

    a_older_row_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_upd |-> $past(upd))
        else $error("older line written without a sample item");
`endif

endmodule

// ===== hw/rtl/gfps_stencil.sv =====
module gfps_stencil #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gfps_pkg::t_item_ctrl           i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_centre,
    input  logic signed [SAMPLE_WIDTH-1:0] i_north,
    input  logic signed [SAMPLE_WIDTH-1:0] i_south,
    input  logic signed [SAMPLE_WIDTH-1:0] i_east,
    input  logic signed [SAMPLE_WIDTH-1:0] i_west,
    output gfps_pkg::t_item_ctrl           o_ctrl,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic [1:0]                     o_busy
);
    import gfps_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + 3;

    t_item_ctrl                     r_a_ctrl, r_b_ctrl;
    logic signed [SUM_W-1:0]        r_a_p, r_a_q;
    logic signed [SAMPLE_WIDTH-1:0] r_a_west, r_a_centre, r_b_value;
    logic signed [SUM_W-1:0]        n_a_p, n_a_q, sum;
    logic signed [SAMPLE_WIDTH-1:0] n_b_value;

    // first half of the weighted sum
    always_comb begin
        n_a_p = (SUM_W'(i_centre) <<< 2) + SUM_W'(i_north);
        n_a_q = SUM_W'(i_south) + SUM_W'(i_east);
    end

    // rest of the sum, floor divide by eight, border pass-through
    always_comb begin
        sum       = r_a_p + r_a_q + SUM_W'(r_a_west);
        n_b_value = r_a_ctrl.interior ? sum[SUM_W-1:3] : r_a_centre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl <= '0;
            r_b_ctrl <= '0;
        end else begin
            r_a_ctrl <= i_ctrl;
            r_b_ctrl <= r_a_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_p      <= n_a_p;
        r_a_q      <= n_a_q;
        r_a_west   <= i_west;
        r_a_centre <= i_centre;
        r_b_value  <= n_b_value;
    end

    assign o_ctrl  = r_b_ctrl;
    assign o_value = r_b_value;
    assign o_busy  = 2'(r_a_ctrl.emit) + 2'(r_b_ctrl.emit);

endmodule

// ===== hw/rtl/gfps_queue.sv =====
module gfps_queue #(
    parameter int DATA_W = 58,
    parameter int DEPTH  = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [DATA_W-1:0]          i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [DATA_W-1:0]          o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import gfps_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]     r_count, n_count;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count < NW'(DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("result queue underflow");
`endif

endmodule

// ===== hw/rtl/grid_five_point_smoothing.sv =====
// Five-point smoother for one layer of a 2D grid streamed in raster order.
// Input channel s_axis: tuser selects a grid sample (0) or a flush item (1),
// tdata carries the signed Q8.16 sample. Output channel m_axis: tdata holds
// the smoothed value, row, column and layer; tlast marks the frame's last point.
// Interior points become floor((4*centre + N + S + E + W) / 8), border points
// pass through. Results trail the input by one row: row r is emitted by the
// samples of row r+1, and after the frame one flush item per column emits the
// last row. Samples beyond the configured row count and flush items before
// the frame end give no result.
// Configuration (i_cfg_*) holds rows, columns and layer; write it while idle.
// After an input accept, m_axis_tvalid rises once the item has passed the buffer
// read register, the two adder stages and the queue write. Throughput is one item
// per cycle while s_axis_tready is high, set by the single-port-write line buffers
// that are read in the accept cycle; the newer row is also written in that cycle.
// s_axis_tready drops only when the 8-entry result queue plus items in flight
// would overflow, so a stalled receiver fills the queue and then holds off the
// sender; nothing is lost. Reset holds s_axis_tready low, empties the queue,
// clears row and column and restores the register defaults; line buffer
// contents are kept as they are.
module grid_five_point_smoothing #(
    parameter int MAX_COLS     = gfps_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_WIDTH = gfps_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input item
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // [SW-1:0] sample
    input  logic                                   s_axis_tuser,  // [0] func
    // result item
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // smoothed, out_row[16], out_col[9], layer[8] from bit 0 up
    output logic [((SAMPLE_WIDTH+33+7)/8)*8-1:0]   m_axis_tdata,
    output logic                                   m_axis_tlast,  // frame_last
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [gfps_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [gfps_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import gfps_pkg::*;

    localparam int IN_TD_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_W    = SAMPLE_WIDTH + ROW_W + OUT_COL_W + LAYER_W;
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;
    localparam int Q_DATA_W = OUT_W + 1;
    localparam int NW       = $clog2(QUEUE_DEPTH + 1);
    localparam int CRW      = NW + 1;

    logic [ROW_W-1:0]      r_rows;
    logic [COLS_REG_W-1:0] r_cols;
    logic [LAYER_W-1:0]    r_layer;

    t_item_ctrl                     s1_ctrl, st_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] s1_centre, s1_north, s1_south, s1_east, s1_west;
    logic signed [SAMPLE_WIDTH-1:0] st_value;
    logic [1:0]                     st_busy;
    logic [Q_DATA_W-1:0]            q_in, q_out;
    logic [NW-1:0]                  q_count;
    logic [CRW-1:0]                 in_flight;
    logic                           accept, pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= ROWS_RESET;
            r_cols  <= COLS_RESET;
            r_layer <= LAYER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ROWS: begin
                    r_rows <= i_cfg_data[ROW_W-1:0];
                end
                REG_COLS: begin
                    r_cols <= i_cfg_data[COLS_REG_W-1:0];
                end
                REG_LAYER: begin
                    r_layer <= i_cfg_data[LAYER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // credit: queue entries plus items still in the pipeline
    always_comb begin
        in_flight = CRW'(q_count) + CRW'(s1_ctrl.emit) + CRW'(st_busy);
        s_axis_tready = i_rst_n && (in_flight < CRW'(QUEUE_DEPTH));
        accept = s_axis_tvalid && s_axis_tready;
    end

    gfps_front #(
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (s_axis_tuser),
        .i_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_rows   (r_rows),
        .i_cols   (r_cols),
        .i_layer  (r_layer),
        .o_ctrl   (s1_ctrl),
        .o_centre (s1_centre),
        .o_north  (s1_north),
        .o_south  (s1_south),
        .o_east   (s1_east),
        .o_west   (s1_west)
    );

    gfps_stencil #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_stencil (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (s1_ctrl),
        .i_centre (s1_centre),
        .i_north  (s1_north),
        .i_south  (s1_south),
        .i_east   (s1_east),
        .i_west   (s1_west),
        .o_ctrl   (st_ctrl),
        .o_value  (st_value),
        .o_busy   (st_busy)
    );

    // result packing, frame_last on top
    assign q_in = {st_ctrl.last, st_ctrl.layer, st_ctrl.col, st_ctrl.row, st_value};
    assign pop  = m_axis_tvalid && m_axis_tready;

    gfps_queue #(
        .DATA_W (Q_DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (st_ctrl.emit),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign m_axis_tdata = OUT_TD_W'(q_out[OUT_W-1:0]);
    assign m_axis_tlast = q_out[Q_DATA_W-1];

endmodule

// ===== tb/tb_grid_five_point_smoothing.sv =====
`timescale 1ns / 100ps

module tb_grid_five_point_smoothing;
    import gfps_pkg::*;

    localparam int LINE_LEN    = 512;
    localparam int SAMPLE_W    = 24;
    localparam int IN_BITS     = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_BITS    = ((SAMPLE_W + 33 + 7) / 8) * 8;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 3000000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_BITS-1:0]      s_axis_tdata = '0;   // [23:0] sample
    logic                    s_axis_tuser = 1'b0; // [0] func
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [23:0] smoothed, [39:24] out_row, [48:40] out_col, [56:49] layer
    logic [OUT_BITS-1:0]     m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          long_hold_req = 1'b0;
    int unsigned useful_items = 0;
    int unsigned frames_sent = 0;
    int unsigned cycles = 0;

    grid_five_point_smoothing #(
        .MAX_COLS     (LINE_LEN),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // one emitted grid point
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic [ROW_W-1:0]           row;
        logic [OUT_COL_W-1:0]       col;
        logic [LAYER_W-1:0]         layer;
        logic                       last;
    } t_smooth_point;

    // smoother state mirror plus the points still owed by the block
    class t_smoothing_board;
        logic [ROW_W-1:0]           rows_reg;
        logic [COLS_REG_W-1:0]      cols_reg;
        logic [LAYER_W-1:0]         layer_reg;
        logic signed [SAMPLE_W-1:0] line_above [LINE_LEN];
        logic signed [SAMPLE_W-1:0] line_two_above [LINE_LEN];
        logic signed [SAMPLE_W-1:0] left_val;
        int unsigned                row_at;
        int unsigned                col_at;
        t_smooth_point              due_points [$];
        int unsigned                items_seen;
        int unsigned                items_ignored;
        int unsigned                points_checked;
        int unsigned                mismatches;

        function new();
            rows_reg  = ROWS_RESET;
            cols_reg  = COLS_RESET;
            layer_reg = LAYER_RESET;
            foreach (line_above[i]) begin
                line_above[i]     = '0;
                line_two_above[i] = '0;
            end
            left_val       = '0;
            row_at         = 0;
            col_at         = 0;
            items_seen     = 0;
            items_ignored  = 0;
            points_checked = 0;
            mismatches     = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_ROWS:  rows_reg  = v[ROW_W-1:0];
                REG_COLS:  cols_reg  = v[COLS_REG_W-1:0];
                REG_LAYER: layer_reg = v[LAYER_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the smoother by one accepted item, queue the point it emits
        function void note_item(logic func, logic [SAMPLE_W-1:0] raw);
            int unsigned                nrows, ncols, c, e;
            bit                         frame_done;
            longint                     acc, avg;
            logic signed [SAMPLE_W-1:0] centre, south;
            t_smooth_point              p;
            items_seen++;
            nrows = (rows_reg == 0) ? 1 : rows_reg;
            ncols = (cols_reg == 0) ? 1 : ((cols_reg > LINE_LEN) ? LINE_LEN : cols_reg);
            c = (col_at >= LINE_LEN) ? LINE_LEN - 1 : col_at;
            frame_done = (row_at >= nrows);
            p.layer = layer_reg;
            p.last  = 1'b0;

            // flush emits the final row unchanged
            if (func == FUNC_FLUSH) begin
                if (!frame_done) begin
                    items_ignored++;
                    return;
                end
                p.value = line_above[c];
                p.row   = ROW_W'(nrows - 1);
                p.col   = col_at[OUT_COL_W-1:0];
                p.last  = (col_at + 1 >= ncols);
                due_points = {due_points, p};
                if (p.last) begin
                    row_at = 0;
                    col_at = 0;
                end else begin
                    col_at++;
                end
                return;
            end

            if (frame_done) begin
                items_ignored++;
                return;
            end

            // sample is the south neighbour of the point one row up
            south  = raw;
            centre = line_above[c];
            if (row_at >= 1) begin
                e = row_at - 1;
                p.value = centre;
                if (e >= 1 && e + 2 <= nrows && c >= 1 && c + 2 <= ncols
                        && c + 1 < LINE_LEN) begin
                    acc = 4 * longint'(centre) + longint'(line_two_above[c])
                        + longint'(south) + longint'(line_above[c + 1])
                        + longint'(left_val);
                    avg = acc >>> 3;
                    p.value = avg[SAMPLE_W-1:0];
                end
                p.row = ROW_W'(e);
                p.col = c[OUT_COL_W-1:0];
                due_points = {due_points, p};
            end
            line_two_above[c] = centre;
            line_above[c]     = south;
            left_val          = centre;

            if (col_at + 1 >= ncols) begin
                col_at = 0;
                row_at++;
            end else begin
                col_at++;
            end
        endfunction

        // compare one emitted point with the oldest one owed
        function void check_point(logic [OUT_BITS-1:0] data, logic last);
            t_smooth_point got, want;
            got.value = data[23:0];
            got.row   = data[39:24];
            got.col   = data[48:40];
            got.layer = data[56:49];
            got.last  = last;
            points_checked++;
            if (due_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point: value %0d row %0d col %0d layer %0d last %0b",
                             got.value, got.row, got.col, got.layer, got.last);
                return;
            end
            want = due_points.pop_front();
            if (got.value !== want.value || got.row !== want.row || got.col !== want.col
                    || got.layer !== want.layer || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("point mismatch at t=%0t", $realtime);
                    $display("  expected value %0d row %0d col %0d layer %0d last %0b",
                             want.value, want.row, want.col, want.layer, want.last);
                    $display("  actual   value %0d row %0d col %0d layer %0d last %0b",
                             got.value, got.row, got.col, got.layer, got.last);
                end
            end
        endfunction
    endclass

    t_smoothing_board board = new();

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // handshake monitor and run limit
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_item(s_axis_tuser, s_axis_tdata[SAMPLE_W-1:0]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_point(m_axis_tdata, m_axis_tlast);
        end
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points still owed",
                     cycles, board.due_points.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample(bit extremes_only);
        logic [31:0] r;
        r = $urandom();
        if (extremes_only)
            return r[0] ? 24'h7FFFFF : 24'h800000;
        case (r[31:28])
            4'd0: return 24'h7FFFFF;
            4'd1: return 24'h800000;
            4'd2: return 24'hFFFFFF;
            4'd3: return {{20{r[4]}}, r[3:0]};  // small values near zero
            default: return r[23:0];
        endcase
    endfunction

    // receiver: random back-pressure, plus one long hold on request
    initial begin
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // offer one item and wait for it to be taken
    task automatic send_item(input logic func, input logic [SAMPLE_W-1:0] v);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every owed point has come out
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.due_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.set_reg(idx, v);
    endtask

    task automatic configure(input logic [ROW_W-1:0] nrows,
                             input logic [COLS_REG_W-1:0] ncols,
                             input logic [LAYER_W-1:0] lay);
        put_reg(REG_ROWS, nrows);
        put_reg(REG_COLS, {{(CFG_DATA_W-COLS_REG_W){1'b0}}, ncols});
        put_reg(REG_LAYER, {{(CFG_DATA_W-LAYER_W){1'b0}}, lay});
        i_cfg_we <= 1'b0;
    endtask

    // one full frame plus its flush row, with optional stray items
    task automatic send_frame(input int unsigned nrows, input int unsigned ncols,
                              input bit noisy, input bit extremes_only);
        for (int unsigned r = 0; r < nrows; r++) begin
            for (int unsigned c = 0; c < ncols; c++) begin
                if (noisy && $urandom_range(0, 99) < 4)
                    send_item(FUNC_FLUSH, rand_sample(1'b0));
                send_item(FUNC_SAMPLE, rand_sample(extremes_only));
            end
        end
        if (noisy && $urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 2)) send_item(FUNC_SAMPLE, rand_sample(1'b0));
        for (int unsigned c = 0; c < ncols; c++)
            send_item(FUNC_FLUSH, rand_sample(1'b0));
        useful_items += nrows * ncols + ncols;
        frames_sent++;
    endtask

    // stimulus
    initial begin
        int unsigned nrows, ncols, target;
        bit          fresh;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed 3x3 frame: extremes on the border, floor of a negative sum inside
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        configure(16'd3, 10'd3, 8'hFF);
        send_item(FUNC_FLUSH, 24'h123456);   // flush while the frame is open
        send_item(FUNC_SAMPLE, 24'h7FFFFF);
        send_item(FUNC_SAMPLE, 24'h800000);
        send_item(FUNC_SAMPLE, 24'h000001);
        send_item(FUNC_SAMPLE, 24'h000003);
        send_item(FUNC_SAMPLE, 24'hFFFFFF);
        send_item(FUNC_SAMPLE, 24'h000000);
        send_item(FUNC_SAMPLE, 24'h800000);
        send_item(FUNC_SAMPLE, 24'h7FFFFF);
        send_item(FUNC_SAMPLE, 24'hFFFFFE);
        send_item(FUNC_SAMPLE, 24'h5A5A5A);  // sample after the frame is complete
        send_item(FUNC_FLUSH, 24'h000000);
        send_item(FUNC_FLUSH, 24'hFFFFFF);
        send_item(FUNC_FLUSH, 24'hA5A5A5);
        frames_sent++;
        drain_block();

        // single point frame
        configure(16'd1, 10'd1, 8'h00);
        send_item(FUNC_FLUSH, 24'h000000);
        send_item(FUNC_SAMPLE, 24'hC0FFEE);
        send_item(FUNC_SAMPLE, 24'h111111);
        send_item(FUNC_FLUSH, 24'h000000);
        frames_sent++;
        drain_block();

        // widest row; the receiver holds off during the flush row so the input stalls
        configure(16'd1, 10'd512, 8'h5A);
        tx_idle_pct = 0;
        rx_idle_pct = 10;
        for (int unsigned c = 0; c < LINE_LEN; c++)
            send_item(FUNC_SAMPLE, rand_sample(1'b0));
        long_hold_req = 1'b1;
        for (int unsigned c = 0; c < LINE_LEN; c++)
            send_item(FUNC_FLUSH, rand_sample(1'b0));
        useful_items += 2 * LINE_LEN;
        frames_sent++;

        // random frames, mostly small, with stray items mixed in
        target = useful_items + 120;
        fresh  = 1'b1;
        while (useful_items < target) begin
            if (fresh || $urandom_range(0, 99) < 60) begin
                drain_block();
                nrows = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                    : $urandom_range(7, 10);
                ncols = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10)
                                                    : $urandom_range(11, 24);
                configure(ROW_W'(nrows), COLS_REG_W'(ncols),
                          LAYER_W'($urandom_range(0, 255)));
                fresh = 1'b0;
            end
            tx_idle_pct = pick_pct();
            rx_idle_pct = pick_pct();
            send_frame(nrows, ncols, 1'b1, $urandom_range(0, 9) == 0);
        end
        drain_block();

        // zero row and column counts act as a single point
        configure(16'd0, 10'd0, 8'h3C);
        tx_idle_pct = 0;
        rx_idle_pct = 10;
        send_item(FUNC_SAMPLE, 24'h400000);
        send_item(FUNC_SAMPLE, 24'h0F0F0F);
        send_item(FUNC_FLUSH, 24'h000000);
        useful_items += 2;
        frames_sent++;
        drain_block();

        $display("covered %0d input items over %0d frames, %0d of them stray and ignored",
                 board.items_seen, frames_sent, board.items_ignored);
        $display("compared %0d points, %0d mismatches; sizes 1x1 up to 1x512 with a held receiver",
                 board.points_checked, board.mismatches);
        if (board.mismatches == 0 && board.due_points.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
